// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_CLK checks a property on the rising clock edge while reset is released.
// ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/mptc_pkg.sv
package mptc_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned OUT_CNT_W = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ADDR = 1'b0,
    REG_END_ADDR   = 1'b1
  } reg_idx_e;

  localparam logic [REG_W-1:0]  START_ADDR_RESET = 32'h0000_0000;
  localparam logic [REG_W-1:0]  END_ADDR_RESET   = 32'h0080_0000;
  localparam logic [BYTE_W-1:0] PATTERN_FIRST    = 8'h01;
  localparam logic [BYTE_W-1:0] PATTERN_LAST     = 8'hFF;

endpackage

// File: rtl/memory_pattern_test_controller_top.sv
// Incrementing-pattern memory self-test sequencer over the byte range
// [start_addr, end_addr). Send a start item (mode 0) to clear the four lane
// error counters, set memory_ok and reload the address pointer and pattern;
// then send write steps (mode 1) until pass_done, another start, and read
// steps (mode 2) with the byte read back until pass_done. Each step names the
// next address and the pattern byte (1..255, zero skipped). A read mismatch
// clears memory_ok and bumps, saturating, the counter picked by address bits
// 2:1. Steps at or past end_addr make no access and flag pass_done. The range
// must satisfy start_addr < end_addr for any access to happen. Rate: one item
// per clock cycle while the output is not stalled, with its result registered
// in the cycle after acceptance; the whole step is a single compare-and-increment
// between handshake and result register, which drains while the next item is taken.
// Configuration writes are always ready; write them only while the block is
// idle. end_addr applies at once, start_addr at the next start item.
module memory_pattern_test_controller_top #(
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mptc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mptc_pkg::REG_W-1:0]          cfg_data_i,
  // item input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mptc_pkg::MODE_W-1:0]         mode_i,
  input  logic [mptc_pkg::BYTE_W-1:0]         read_data_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                access_valid_o,
  output logic [mptc_pkg::OUT_ADDR_W-1:0]     mem_address_o,
  output logic [mptc_pkg::BYTE_W-1:0]         write_data_o,
  output logic                                mismatch_o,
  output logic                                pass_done_o,
  output logic [mptc_pkg::OUT_CNT_W-1:0]      lane_errors_0_o,
  output logic [mptc_pkg::OUT_CNT_W-1:0]      lane_errors_1_o,
  output logic [mptc_pkg::OUT_CNT_W-1:0]      lane_errors_2_o,
  output logic [mptc_pkg::OUT_CNT_W-1:0]      lane_errors_3_o,
  output logic                                memory_ok_o
);

  import mptc_pkg::*;

  `include "assert_macros.svh"

  // Common width for address compares and the address output.
  localparam int unsigned CMP_W = (ADDR_BITS > REG_W) ? ADDR_BITS : REG_W;
  // Common width for presenting the lane counters.
  localparam int unsigned CNT_X_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  // Configuration registers
  logic [REG_W-1:0] start_addr_q;
  logic [REG_W-1:0] end_addr_q;

  // Sequencer state
  logic [ADDR_BITS-1:0]  ptr_q, ptr_d;
  logic [BYTE_W-1:0]     pat_q, pat_d;
  logic [COUNT_BITS-1:0] cnt_q [NUM_LANES];
  logic [COUNT_BITS-1:0] cnt_d [NUM_LANES];
  logic                  ok_q, ok_d;

  // Result register
  logic                  out_valid_q;
  logic                  acc_q, acc_d;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic [BYTE_W-1:0]     wdata_q, wdata_d;
  logic                  mis_q, mis_d;
  logic                  done_q, done_d;

  logic                  in_acc;
  logic [CMP_W-1:0]      start_ext;
  logic [CMP_W-1:0]      end_ext;
  logic [CMP_W-1:0]      ptr_ext;
  logic [CMP_W-1:0]      nxt_ext;
  logic [CMP_W-1:0]      addr_ext;
  logic [ADDR_BITS-1:0]  ptr_nxt;
  logic                  in_range;
  logic [LANE_W-1:0]     lane;
  logic                  bad_byte;

  assign cfg_ready_o = 1'b1;

  // Take a new item whenever the result register is empty or being drained.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= START_ADDR_RESET;
      end_addr_q   <= END_ADDR_RESET;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_START_ADDR: start_addr_q <= cfg_data_i;
        REG_END_ADDR:   end_addr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Range arithmetic on a width that holds both the pointer and the registers.
  assign start_ext = CMP_W'(start_addr_q);
  assign end_ext   = CMP_W'(end_addr_q);
  assign ptr_ext   = CMP_W'(ptr_q);
  assign ptr_nxt   = ptr_q + ADDR_BITS'(1);
  assign nxt_ext   = CMP_W'(ptr_nxt);
  assign in_range  = ptr_ext < end_ext;
  assign lane      = ptr_q[2:1];
  assign bad_byte  = read_data_i != pat_q;

  always_comb begin
    ptr_d   = ptr_q;
    pat_d   = pat_q;
    ok_d    = ok_q;
    cnt_d   = cnt_q;
    acc_d   = 1'b0;
    addr_d  = '0;
    wdata_d = '0;
    mis_d   = 1'b0;
    done_d  = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_START: begin
        // Reload the pointer and pattern, clear the error record.
        ptr_d = start_ext[ADDR_BITS-1:0];
        pat_d = PATTERN_FIRST;
        ok_d  = 1'b1;
        for (int k = 0; k < NUM_LANES; k++) begin
          cnt_d[k] = '0;
        end
      end
      MODE_WRITE, MODE_READ: begin
        if (in_range) begin
          acc_d   = 1'b1;
          addr_d  = ptr_q;
          wdata_d = pat_q;
          if ((mode_e'(mode_i) == MODE_READ) && bad_byte) begin
            mis_d = 1'b1;
            ok_d  = 1'b0;
            // Saturate at all ones.
            if (cnt_q[lane] != '1) begin
              cnt_d[lane] = cnt_q[lane] + COUNT_BITS'(1);
            end
          end
          ptr_d  = ptr_nxt;
          // Finish on the last in-range byte, or when the pointer wraps.
          done_d = (nxt_ext >= end_ext) || (ptr_nxt == '0);
          // Pattern runs 1..255 and skips zero.
          pat_d  = (pat_q == PATTERN_LAST) ? PATTERN_FIRST : pat_q + BYTE_W'(1);
        end else begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= ADDR_BITS'(START_ADDR_RESET);
      pat_q       <= PATTERN_FIRST;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (in_acc) begin
        ptr_q <= ptr_d;
        pat_q <= pat_d;
        ok_q  <= ok_d;
        cnt_q <= cnt_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q   <= acc_d;
      addr_q  <= addr_d;
      wdata_q <= wdata_d;
      mis_q   <= mis_d;
      done_q  <= done_d;
    end
  end

  assign addr_ext       = CMP_W'(addr_q);
  assign out_valid_o    = out_valid_q;
  assign access_valid_o = acc_q;
  assign mem_address_o  = addr_ext[OUT_ADDR_W-1:0];
  assign write_data_o   = wdata_q;
  assign mismatch_o     = mis_q;
  assign pass_done_o    = done_q;

  // Counters and the ok flag change only on acceptance, so the state itself
  // shows the values after the item held in the result register.
  logic [CNT_X_W-1:0] cnt_x [NUM_LANES];
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_cnt_x
    assign cnt_x[g] = CNT_X_W'(cnt_q[g]);
  end

  assign lane_errors_0_o = cnt_x[0][OUT_CNT_W-1:0];
  assign lane_errors_1_o = cnt_x[1][OUT_CNT_W-1:0];
  assign lane_errors_2_o = cnt_x[2][OUT_CNT_W-1:0];
  assign lane_errors_3_o = cnt_x[3][OUT_CNT_W-1:0];
  assign memory_ok_o     = ok_q;

  // ok drops only on an accepted read step that missed.
  `ASSERT_CLK(a_ok_fall_on_miss, clk_i, rst_ni, $fell(ok_q) |-> $past(in_acc && mis_d))
  // The pointer moves only when an item is taken.
  `ASSERT_CLK(a_ptr_on_accept, clk_i, rst_ni, !$stable(ptr_q) |-> $past(in_acc))
  // An access never carries the zero pattern.
  `ASSERT_CLK(a_pat_nonzero, clk_i, rst_ni, (out_valid_q && acc_q) |-> (wdata_q != '0))
  // A miss is always an access and leaves the ok flag low.
  `ASSERT_CLK(a_miss_is_access, clk_i, rst_ni, (out_valid_q && mis_q) |-> (acc_q && !ok_q))

endmodule
